// ===== src/iirl_pkg.sv =====
// Package for the indexed insert/remove list: operation codes, field widths and cell control.
package iirl_pkg;

  // Operation codes carried in the operation field.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Field widths of the input and result items.
  localparam int OP_W    = 2;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 64;
  localparam int COUNT_W = 6;

  // Packed stream widths, filled up to whole bytes.
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;

  // Cell index width, wide enough for the largest list of 256 entries.
  localparam int IDX_W = 8;

  // Cells whose read terms are combined in one register of the read tree.
  localparam int GRP_SIZE = 16;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;  // open a gap at pos and load the new element there
    logic             rem;  // close the gap at pos by pulling from the right
    logic [IDX_W-1:0] pos;  // element index the command refers to
  } cell_ctrl_t;

endpackage

// ===== src/iirl_cell.sv =====
// One storage cell of the list chain: holds, shifts or loads one element.
module iirl_cell
  import iirl_pkg::*;
#(
  parameter int ELEMENT_BITS = 64,
  parameter int CELL_IDX     = 0
) (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic [ELEMENT_BITS-1:0] left_q,   // element held by the cell below
  input  logic [ELEMENT_BITS-1:0] right_q,  // element held by the cell above
  input  logic [ELEMENT_BITS-1:0] load_d,   // new element for an insert
  output logic [ELEMENT_BITS-1:0] q,
  output logic [ELEMENT_BITS-1:0] rd_term   // own element when addressed, else zero
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [ELEMENT_BITS-1:0] data_r;
  logic [ELEMENT_BITS-1:0] data_nxt;
  logic                    hit;
  logic                    above;

  assign hit   = (ctrl.pos == MY_IDX);
  assign above = (MY_IDX > ctrl.pos);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (hit) begin
        data_nxt = load_d;
      end else if (above) begin
        data_nxt = left_q;
      end
    end else if (ctrl.rem) begin
      if (hit || above) begin
        data_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q       = data_r;
  assign rd_term = hit ? data_r : '0;

endmodule

// ===== src/indexed_insert_remove_list.sv =====
// Top level of the indexed insert/remove list: control sequencer, cell chain and read tree.
//
// The block keeps an ordered list of up to DEPTH elements in a chain of cells, one
// element per cell. Each input item on the in_ channel carries an operation (insert,
// remove or read), a signed position and a data word; a negative position means the
// end of the list. Every item gives exactly one result item on the out_ channel with
// an accepted flag, the removed or read element (zero otherwise) and the element
// count after the operation, taken modulo 64.
//
// An item passes in order through the accepting edge, an edge at which every cell shifts,
// holds or loads on its own and the addressed cell's element is gathered into sixteen-
// cell groups, and an edge at which the groups are combined into the output register.
// The input stays closed until that result is placed, so no new item is accepted while
// one is in progress; the two-level read tree sets the length of that sequence.
//
// The result sits in an output register, so the next item is accepted while a result
// still waits. If the receiver stalls, the following result waits in the last step
// until the output register is free, and the input stays closed meanwhile.
//
// Reset empties the list and drops any result not yet taken. Cell contents are not
// cleared; entries beyond the count are never returned.
module indexed_insert_remove_list
  import iirl_pkg::*;
#(
  parameter int DEPTH        = 32,
  parameter int ELEMENT_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input items.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // operation[1:0], position[8:2], data_in[72:9]
  // Result items.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // accepted[0], data_out[64:1], element_count[70:65]
);

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int IW     = $clog2(DEPTH);
  localparam int CMP_W  = (CW > POS_W - 1) ? CW : POS_W - 1;
  localparam int GROUPS = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for an item
    S_EXEC,   // cells update, read groups are captured
    S_SEL     // groups combined, result placed in the output register
  } state_t;

  state_t state_r, state_nxt;

  // The accepted item.
  logic [OP_W-1:0]         op_r,  op_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [ELEMENT_BITS-1:0] din_r, din_nxt;

  // List length and the outcome of the current item.
  logic [CW-1:0]           count_r, count_nxt;
  logic                    ok_r,    ok_nxt;
  logic                    rd_r,    rd_nxt;

  // Result register.
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_acc_r,   out_acc_nxt;
  logic [DATA_W-1:0]       out_data_r,  out_data_nxt;
  logic [COUNT_W-1:0]      out_cnt_r,   out_cnt_nxt;

  // Read tree, first level.
  logic [ELEMENT_BITS-1:0] grp_r   [GROUPS];
  logic [ELEMENT_BITS-1:0] grp_nxt [GROUPS];
  logic [ELEMENT_BITS-1:0] grp_or;

  // Chain signals.
  logic [ELEMENT_BITS-1:0] cell_q  [DEPTH];
  logic [ELEMENT_BITS-1:0] rd_term [DEPTH];
  cell_ctrl_t              ctrl;

  // Decode of the held item.
  logic                    at_end;
  logic [CMP_W-1:0]        pos_x;
  logic [CMP_W-1:0]        cnt_x;
  logic                    is_ins;
  logic                    is_acc;
  logic                    ins_ok;
  logic                    acc_ok;
  logic                    item_ok;
  logic [CMP_W-1:0]        eff_x;
  logic [IW-1:0]           eff_idx;
  logic                    accept_in;

  assign accept_in = in_tvalid && in_tready;

  // A negative position points at the end of the list; otherwise the low six bits
  // are the index.
  assign at_end = pos_r[POS_W-1];
  assign pos_x  = CMP_W'(pos_r[POS_W-2:0]);
  assign cnt_x  = CMP_W'(count_r);
  assign is_ins = (op_r == OP_INSERT);
  assign is_acc = (op_r == OP_REMOVE) || (op_r == OP_READ);

  // An insert needs free room and a position no further than the count; a remove or
  // read needs an element at the position.
  assign ins_ok  = (count_r != CW'(DEPTH)) && (at_end || (pos_x <= cnt_x));
  assign acc_ok  = (count_r != '0) && (at_end || (pos_x < cnt_x));
  assign item_ok = (is_ins && ins_ok) || (is_acc && acc_ok);

  always_comb begin
    if (!at_end) begin
      eff_x = pos_x;
    end else if (is_ins) begin
      eff_x = cnt_x;
    end else begin
      eff_x = cnt_x - CMP_W'(1);
    end
  end

  // Only meaningful when the item is carried out, which keeps the index below DEPTH.
  assign eff_idx = eff_x[IW-1:0];

  always_comb begin
    ctrl.ins = (state_r == S_EXEC) && item_ok && is_ins;
    ctrl.rem = (state_r == S_EXEC) && item_ok && (op_r == OP_REMOVE);
    ctrl.pos = IDX_W'(eff_idx);
  end

  // The chain of cells; the ends see zeros where they have no neighbour.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_q;
    logic [ELEMENT_BITS-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    iirl_cell #(
      .ELEMENT_BITS (ELEMENT_BITS),
      .CELL_IDX     (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_q  (left_q),
      .right_q (right_q),
      .load_d  (din_r),
      .q       (cell_q[i]),
      .rd_term (rd_term[i])
    );
  end

  // First level of the read tree: each group ORs the read terms of its cells. At most
  // one cell is addressed, so the OR is a select.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | rd_term[g * GRP_SIZE + k];
        end
      end
    end
  end

  // Second level: combine the group registers.
  always_comb begin
    grp_or = '0;
    for (int g = 0; g < GROUPS; g++) begin
      grp_or = grp_or | grp_r[g];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    din_nxt       = din_r;
    count_nxt     = count_r;
    ok_nxt        = ok_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r;
    out_acc_nxt   = out_acc_r;
    out_data_nxt  = out_data_r;
    out_cnt_nxt   = out_cnt_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          op_nxt    = in_tdata[OP_W-1:0];
          pos_nxt   = in_tdata[OP_W +: POS_W];
          din_nxt   = in_tdata[OP_W + POS_W +: ELEMENT_BITS];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ok_nxt = item_ok;
        rd_nxt = item_ok && is_acc;
        if (item_ok && is_ins) begin
          count_nxt = count_r + CW'(1);
        end else if (item_ok && (op_r == OP_REMOVE)) begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = ok_r;
          out_data_nxt  = rd_r ? DATA_W'(grp_or) : '0;
          out_cnt_nxt   = cnt_x[COUNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    din_r      <= din_nxt;
    ok_r       <= ok_nxt;
    rd_r       <= rd_nxt;
    out_acc_r  <= out_acc_nxt;
    out_data_r <= out_data_nxt;
    out_cnt_r  <= out_cnt_nxt;
    // The groups are captured only as the cells update, so a stalled result keeps the
    // element as it was before a remove closed the gap.
    if (state_r == S_EXEC) begin
      for (int g = 0; g < GROUPS; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_data_r, out_acc_r};

endmodule

// ===== src/iirl_chk.sv =====
// Port-level checker for the indexed insert/remove list, bound to the top level.
module iirl_chk
  import iirl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A refused operation returns no data.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[DATA_W:1] == '0))
    else $error("refused result carries data");

  // Items are taken one at a time: the input closes after every accepted item.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // Reset drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    !$past(rst_n) && rst_n |-> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind indexed_insert_remove_list iirl_chk u_iirl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
